// ----- src/rlpd_pkg.sv -----
// Package for the rotating LED PWM driver: duty table, debounce codes and sizes.
`default_nettype none

package rlpd_pkg;

  localparam int unsigned LedCount = 8;
  localparam logic [5:0] DebounceTicks = 6'd40;

  typedef logic [LedCount-1:0] led_vec_t;

  typedef enum logic [1:0] {
    DB_WAIT_PRESS   = 2'd0,
    DB_TIME_PRESS   = 2'd1,
    DB_WAIT_RELEASE = 2'd2,
    DB_TIME_RELEASE = 2'd3
  } debounce_e;

  // Duty per row position: LED lit while step (1..32) is at most this value.
  function automatic logic [4:0] duty_at(input logic [2:0] idx);
    logic [4:0] duty;
    case (idx)
      3'd0:    duty = 5'd31;
      3'd1:    duty = 5'd20;
      3'd2:    duty = 5'd11;
      3'd3:    duty = 5'd7;
      3'd4:    duty = 5'd4;
      3'd5:    duty = 5'd2;
      3'd6:    duty = 5'd1;
      default: duty = 5'd0;
    endcase
    return duty;
  endfunction

endpackage

`default_nettype wire

// ----- src/rotating_led_pwm_driver.sv -----
// Top level of the rotating LED PWM driver.
`default_nettype none

// Eight-LED PWM chaser. Every accepted request carries a PWM tick, a
// millisecond tick, the raw active-low button level and the rotation speed.
// It produces exactly one result: the LED pattern and the direction after
// that request. The block takes one request per clock unless in_stall_o is
// high. A request is held in the input register. The PWM, rotation and
// debounce updates then run combinationally into the result register. The
// result register lets a new request be accepted while the previous result
// still waits on out_stall_i. The input stalls only when both registers are
// full and out_stall_i is high.
module rotating_led_pwm_driver (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire                      pwm_tick_i,
  input  wire                      ms_tick_i,
  input  wire                      button_level_i,
  input  wire  [7:0]               speed_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output rlpd_pkg::led_vec_t       led_pattern_o,
  output logic                     direction_down_o
);

  import rlpd_pkg::*;

  // Input register
  logic       s1_valid_q;
  logic       pwm_tick_q;
  logic       ms_tick_q;
  logic       button_level_q;
  logic [7:0] speed_q;

  // Block state
  logic [4:0] pwm_count_q, pwm_count_d;
  logic [2:0] phase_q, phase_d;
  logic       dir_neg_q, dir_neg_d;
  logic [8:0] roll_count_q, roll_count_d;
  debounce_e  db_state_q, db_state_d;
  logic [5:0] db_count_q, db_count_d;
  led_vec_t   led_q, led_d;

  // Result register
  logic       out_valid_q;
  led_vec_t   led_out_q;
  logic       dir_out_q;

  logic in_load;
  logic out_load;
  logic advance;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;
  assign advance    = s1_valid_q && out_load;

  // PWM step with old phase and direction
  logic [5:0] step;
  led_vec_t   pattern;

  always_comb begin
    logic [2:0] idx;
    step    = {1'b0, pwm_count_q} + 6'd1;
    pattern = '0;
    for (int i = 0; i < LedCount; i++) begin
      idx        = dir_neg_q ? (phase_q - 3'(i)) : (phase_q + 3'(i));
      pattern[i] = (step <= {1'b0, duty_at(idx)});
    end
  end

  always_comb begin
    pwm_count_d = pwm_count_q;
    led_d       = led_q;
    if (pwm_tick_q) begin
      pwm_count_d = step[4:0];
      led_d       = pattern;
    end
  end

  // Rotation
  logic [8:0] roll_inc;

  always_comb begin
    roll_inc     = roll_count_q + 9'd1;
    roll_count_d = roll_count_q;
    phase_d      = phase_q;
    if (ms_tick_q) begin
      if (roll_inc > {1'b0, speed_q}) begin
        roll_count_d = '0;
        phase_d      = phase_q + 3'd1;
      end else begin
        roll_count_d = roll_inc;
      end
    end
  end

  // Debounce
  logic       pressed;
  logic [5:0] db_inc;
  logic       db_done;

  assign pressed = !button_level_q;
  assign db_inc  = db_count_q + 6'd1;
  assign db_done = (db_inc >= DebounceTicks);

  always_comb begin
    db_state_d = db_state_q;
    if (ms_tick_q) begin
      case (db_state_q)
        DB_WAIT_PRESS:   if (pressed) db_state_d = DB_TIME_PRESS;
        DB_TIME_PRESS:   if (db_done) db_state_d = pressed ? DB_WAIT_RELEASE : DB_WAIT_PRESS;
        DB_WAIT_RELEASE: if (!pressed) db_state_d = DB_TIME_RELEASE;
        DB_TIME_RELEASE: if (db_done) db_state_d = pressed ? DB_WAIT_RELEASE : DB_WAIT_PRESS;
        default:         db_state_d = DB_WAIT_PRESS;
      endcase
    end
  end

  always_comb begin
    db_count_d = db_count_q;
    dir_neg_d  = dir_neg_q;
    if (ms_tick_q) begin
      case (db_state_q)
        DB_WAIT_PRESS:   if (pressed) db_count_d = '0;
        DB_TIME_PRESS: begin
          db_count_d = db_done ? 6'd0 : db_inc;
          if (db_done && pressed) dir_neg_d = !dir_neg_q;
        end
        DB_WAIT_RELEASE: if (!pressed) db_count_d = '0;
        DB_TIME_RELEASE: db_count_d = db_done ? 6'd0 : db_inc;
        default:         db_count_d = db_count_q;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pwm_count_q  <= '0;
      phase_q      <= '0;
      dir_neg_q    <= 1'b0;
      roll_count_q <= '0;
      db_state_q   <= DB_WAIT_PRESS;
      db_count_q   <= '0;
      led_q        <= '0;
    end else begin
      if (in_load) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (advance) begin
        pwm_count_q  <= pwm_count_d;
        phase_q      <= phase_d;
        dir_neg_q    <= dir_neg_d;
        roll_count_q <= roll_count_d;
        db_state_q   <= db_state_d;
        db_count_q   <= db_count_d;
        led_q        <= led_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      pwm_tick_q     <= pwm_tick_i;
      ms_tick_q      <= ms_tick_i;
      button_level_q <= button_level_i;
      speed_q        <= speed_i;
    end
    if (advance) begin
      led_out_q <= led_d;
      dir_out_q <= dir_neg_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign led_pattern_o    = led_out_q;
  assign direction_down_o = dir_out_q;

endmodule

`default_nettype wire
